@@ hdl/tlms_pkg.sv @@
// Package for the marquee text scroller: shared constants, command word type
// and the fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlms_pkg;

    localparam int WINDOW_COLS = 16;
    localparam int MAX_TEXT    = 48;
    localparam int NUM_LINES   = 2;

    localparam int COL_W  = 4;
    localparam int LEN_W  = 6;
    localparam int POS_W  = 7;
    localparam int LINE_W = 1;
    localparam int ADDR_W = 7;
    localparam int STEP_W = 16;

    localparam logic [7:0]        SPACE_CHAR = 8'h20;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd400;
    localparam logic [STEP_W-1:0] TICK_MAX   = 16'hFFFF;

    localparam logic [0:0] REG_STEP = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_COMMIT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [LINE_W-1:0] line;
        logic [5:0]       pos;
        logic [7:0]       char_code;
        logic [LEN_W-1:0] len;
    } cmd_t;

endpackage
`default_nettype wire

@@ hdl/text_line_marquee_scroller_top.sv @@
// Marquee scroller top level: a commit renders 16 characters, a tick 0, 16 or 32,
// at one character per cycle from the text store read stage unless m_ready stalls
// the output; the engine takes no new command until a render is through.
// Loads and clears are done in the render engine and produce no output.
// Synchronous active-low reset clears line lengths, positions, tick counts and
// the step register (400); the text store is not cleared and needs no pass.
`timescale 1ns / 1ps
`default_nettype none
module text_line_marquee_scroller_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_opcode,
    input  wire  [0:0]  s_line_select,
    input  wire  [5:0]  s_text_position,
    input  wire  [7:0]  s_char_code,
    input  wire  [5:0]  s_text_length,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [0:0]  m_row,
    output logic [3:0]  m_column,
    output logic [7:0]  m_glyph,
    output logic        m_last_of_run,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [tlms_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        cfg_wr;

    logic            f_valid, f_ready;
    tlms_pkg::cmd_t  f_cmd;
    logic            q_valid, q_ready;
    tlms_pkg::cmd_t  q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tlms_pkg::REG_STEP);

    always_comb begin
        step_next = step_reg;
        if (cfg_wr) begin
            step_next = pwdata[tlms_pkg::STEP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= tlms_pkg::STEP_RESET;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        if (paddr[2] == tlms_pkg::REG_STEP) begin
            prdata = {16'd0, step_reg};
        end else begin
            prdata = '0;
        end
    end

    tlms_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_line_select   (s_line_select),
        .s_text_position (s_text_position),
        .s_char_code     (s_char_code),
        .s_text_length   (s_text_length),
        .cmd_valid       (f_valid),
        .cmd_ready       (f_ready),
        .cmd             (f_cmd)
    );

    tlms_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    tlms_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_ticks    (step_reg),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd           (q_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row         (m_row),
        .m_column      (m_column),
        .m_glyph       (m_glyph),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire

@@ hdl/tlms_front.sv @@
// Front end: accepts input words, drops loads outside the text store, caps
// commit lengths and hands decoded commands on. Depends on tlms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlms_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire  [1:0]        s_opcode,
    input  wire  [0:0]        s_line_select,
    input  wire  [5:0]        s_text_position,
    input  wire  [7:0]        s_char_code,
    input  wire  [5:0]        s_text_length,
    output logic              cmd_valid,
    input  wire               cmd_ready,
    output tlms_pkg::cmd_t    cmd
);

    logic            slot_valid_reg, slot_valid_next;
    tlms_pkg::cmd_t  slot_reg;
    tlms_pkg::cmd_t  decoded;
    logic            keep;
    logic            accept;

    always_comb begin
        decoded.op        = tlms_pkg::op_t'(s_opcode);
        decoded.line      = s_line_select;
        decoded.pos       = s_text_position;
        decoded.char_code = s_char_code;
        if (s_text_length > 6'(tlms_pkg::MAX_TEXT)) begin
            decoded.len = 6'(tlms_pkg::MAX_TEXT);
        end else begin
            decoded.len = s_text_length;
        end
        // A load beyond the store has no effect and produces no output.
        keep = !((decoded.op == tlms_pkg::OP_LOAD) &&
                 (s_text_position >= 6'(tlms_pkg::MAX_TEXT)));
    end

    assign s_ready   = !slot_valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = slot_valid_reg;
    assign cmd       = slot_reg;

    always_comb begin
        slot_valid_next = slot_valid_reg;
        if (accept) begin
            slot_valid_next = keep;
        end else if (cmd_ready) begin
            slot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
        end else begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg <= decoded;
        end
    end

endmodule
`default_nettype wire

@@ hdl/tlms_fifo.sv @@
// Four-entry command queue between the front end and the render engine.
// Depends on tlms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlms_fifo (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   wr_valid,
    output logic                  wr_ready,
    input  wire  tlms_pkg::cmd_t  wr_data,
    output logic                  rd_valid,
    input  wire                   rd_ready,
    output tlms_pkg::cmd_t        rd_data
);

    localparam int DEPTH = 4;
    localparam int IDX_W = 2;

    tlms_pkg::cmd_t       entry_reg [DEPTH];
    logic [IDX_W:0]       wr_ptr_reg, wr_ptr_next;
    logic [IDX_W:0]       rd_ptr_reg, rd_ptr_next;
    logic                 full;
    logic                 empty;
    logic                 push;
    logic                 pop;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[IDX_W] != rd_ptr_reg[IDX_W]) &&
                      (wr_ptr_reg[IDX_W-1:0] == rd_ptr_reg[IDX_W-1:0]);
    assign wr_ready = !full;
    assign rd_valid = !empty;
    assign push     = wr_valid && !full;
    assign pop      = rd_ready && !empty;
    assign rd_data  = entry_reg[rd_ptr_reg[IDX_W-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (IDX_W+1)'(push);
    assign rd_ptr_next = rd_ptr_reg + (IDX_W+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg[IDX_W-1:0]] <= wr_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/tlms_back.sv @@
// Render engine: holds the text store and per-line state, executes commands
// and streams rendered characters through a read stage and an output
// register. Depends on tlms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlms_back (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  [tlms_pkg::STEP_W-1:0]         step_ticks,
    input  wire                                 cmd_valid,
    output logic                                cmd_ready,
    input  wire  tlms_pkg::cmd_t                cmd,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [0:0]                          m_row,
    output logic [3:0]                          m_column,
    output logic [7:0]                          m_glyph,
    output logic                                m_last_of_run
);

    localparam int NL = tlms_pkg::NUM_LINES;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_RENDER = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [tlms_pkg::LEN_W-1:0]  len_reg  [NL];
    logic [tlms_pkg::LEN_W-1:0]  len_next [NL];
    logic [tlms_pkg::POS_W-1:0]  pos_reg  [NL];
    logic [tlms_pkg::POS_W-1:0]  pos_next [NL];
    logic [tlms_pkg::STEP_W-1:0] elap_reg  [NL];
    logic [tlms_pkg::STEP_W-1:0] elap_next [NL];
    logic [NL-1:0]               pend_reg, pend_next;
    logic [tlms_pkg::LINE_W-1:0] line_reg, line_next;
    logic [tlms_pkg::COL_W-1:0]  col_reg, col_next;

    logic [7:0] text_mem [NL * tlms_pkg::MAX_TEXT];
    logic [7:0] rd_data_reg;

    // Read stage and output register.
    logic                        b_valid_reg, b_valid_next;
    logic                        b_space_reg;
    logic [tlms_pkg::LINE_W-1:0] b_row_reg;
    logic [tlms_pkg::COL_W-1:0]  b_col_reg;
    logic                        b_last_reg;
    logic                        c_valid_reg, c_valid_next;
    logic [tlms_pkg::LINE_W-1:0] c_row_reg;
    logic [tlms_pkg::COL_W-1:0]  c_col_reg;
    logic [7:0]                  c_glyph_reg;
    logic                        c_last_reg;

    logic                        pop;
    logic                        mem_wr;
    logic [tlms_pkg::ADDR_W-1:0] wr_addr;
    logic                        issue;
    logic                        b_move;
    logic                        last_col;
    logic [tlms_pkg::LEN_W-1:0]  cur_len;
    logic [tlms_pkg::POS_W-1:0]  cur_pos;
    logic [tlms_pkg::POS_W-1:0]  span;
    logic [tlms_pkg::POS_W-1:0]  sum;
    logic [tlms_pkg::POS_W-1:0]  idx;
    logic                        is_space;
    logic [tlms_pkg::ADDR_W-1:0] rd_addr;
    logic [NL-1:0]               pend_rest;
    logic [tlms_pkg::LINE_W-1:0] rest_first;
    logic [NL-1:0]               fire;
    logic [tlms_pkg::LINE_W-1:0] fire_first;
    logic [tlms_pkg::STEP_W-1:0] elap_inc [NL];
    logic [tlms_pkg::POS_W-1:0]  wrap_pos [NL];
    logic [tlms_pkg::POS_W-1:0]  line_span [NL];

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign mem_wr    = pop && (cmd.op == tlms_pkg::OP_LOAD);
    assign wr_addr   = tlms_pkg::ADDR_W'(cmd.line) * tlms_pkg::ADDR_W'(tlms_pkg::MAX_TEXT) +
                       tlms_pkg::ADDR_W'(cmd.pos);

    assign b_move   = b_valid_reg && (!c_valid_reg || m_ready);
    assign issue    = (state_reg == ST_RENDER) && (!b_valid_reg || b_move);
    assign last_col = (col_reg == tlms_pkg::COL_W'(tlms_pkg::WINDOW_COLS - 1));

    // Window index of the current column, wrapped once around the scroll span.
    always_comb begin
        cur_len = len_reg[line_reg];
        cur_pos = pos_reg[line_reg];
        span    = tlms_pkg::POS_W'(cur_len) + tlms_pkg::POS_W'(tlms_pkg::WINDOW_COLS);
        sum     = cur_pos + tlms_pkg::POS_W'(col_reg);
        if (cur_len <= tlms_pkg::LEN_W'(tlms_pkg::WINDOW_COLS)) begin
            idx = tlms_pkg::POS_W'(col_reg);
        end else if (sum >= span) begin
            idx = sum - span;
        end else begin
            idx = sum;
        end
        is_space = (idx >= tlms_pkg::POS_W'(cur_len));
        rd_addr  = tlms_pkg::ADDR_W'(line_reg) * tlms_pkg::ADDR_W'(tlms_pkg::MAX_TEXT) +
                   tlms_pkg::ADDR_W'(idx[tlms_pkg::LEN_W-1:0]);
    end

    // Lines still waiting to be rendered after the current one.
    always_comb begin
        pend_rest = pend_reg;
        pend_rest[line_reg] = 1'b0;
        rest_first = '0;
        for (int l = NL - 1; l >= 0; l--) begin
            if (pend_rest[l]) begin
                rest_first = tlms_pkg::LINE_W'(l);
            end
        end
    end

    // Tick evaluation for every line, using the incremented counts.
    always_comb begin
        fire_first = '0;
        for (int l = 0; l < NL; l++) begin
            if (elap_reg[l] != tlms_pkg::TICK_MAX) begin
                elap_inc[l] = elap_reg[l] + 16'd1;
            end else begin
                elap_inc[l] = elap_reg[l];
            end
            fire[l] = (len_reg[l] > tlms_pkg::LEN_W'(tlms_pkg::WINDOW_COLS)) &&
                      (elap_inc[l] >= step_ticks);
            line_span[l] = tlms_pkg::POS_W'(len_reg[l]) +
                           tlms_pkg::POS_W'(tlms_pkg::WINDOW_COLS);
            if (pos_reg[l] + 7'd1 >= line_span[l]) begin
                wrap_pos[l] = pos_reg[l] + 7'd1 - line_span[l];
            end else begin
                wrap_pos[l] = pos_reg[l] + 7'd1;
            end
        end
        for (int l = NL - 1; l >= 0; l--) begin
            if (fire[l]) begin
                fire_first = tlms_pkg::LINE_W'(l);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        for (int l = 0; l < NL; l++) begin
            len_next[l]  = len_reg[l];
            pos_next[l]  = pos_reg[l];
            elap_next[l] = elap_reg[l];
        end
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    case (cmd.op)
                        tlms_pkg::OP_COMMIT: begin
                            len_next[cmd.line]  = cmd.len;
                            pos_next[cmd.line]  = '0;
                            elap_next[cmd.line] = '0;
                            pend_next           = '0;
                            pend_next[cmd.line] = 1'b1;
                            line_next           = cmd.line;
                            col_next            = '0;
                            state_next          = ST_RENDER;
                        end
                        tlms_pkg::OP_CLEAR: begin
                            for (int l = 0; l < NL; l++) begin
                                len_next[l] = '0;
                                pos_next[l] = '0;
                            end
                        end
                        tlms_pkg::OP_TICK: begin
                            for (int l = 0; l < NL; l++) begin
                                if (fire[l]) begin
                                    elap_next[l] = '0;
                                    pos_next[l]  = wrap_pos[l];
                                end else begin
                                    elap_next[l] = elap_inc[l];
                                end
                            end
                            pend_next = fire;
                            line_next = fire_first;
                            col_next  = '0;
                            if (fire != '0) begin
                                state_next = ST_RENDER;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RENDER: begin
                if (issue) begin
                    col_next = col_reg + tlms_pkg::COL_W'(1);
                    if (last_col) begin
                        pend_next = pend_rest;
                        line_next = rest_first;
                        if (pend_rest == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (issue) begin
            b_valid_next = 1'b1;
        end else if (b_move) begin
            b_valid_next = 1'b0;
        end
        c_valid_next = c_valid_reg;
        if (b_move) begin
            c_valid_next = 1'b1;
        end else if (m_ready) begin
            c_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= '0;
            line_reg    <= '0;
            col_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            for (int l = 0; l < NL; l++) begin
                len_reg[l]  <= '0;
                pos_reg[l]  <= '0;
                elap_reg[l] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            for (int l = 0; l < NL; l++) begin
                len_reg[l]  <= len_next[l];
                pos_reg[l]  <= pos_next[l];
                elap_reg[l] <= elap_next[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            text_mem[wr_addr] <= cmd.char_code;
        end
        if (issue) begin
            rd_data_reg <= text_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b_space_reg <= is_space;
            b_row_reg   <= line_reg;
            b_col_reg   <= col_reg;
            b_last_reg  <= last_col && (pend_rest == '0);
        end
        if (b_move) begin
            c_row_reg   <= b_row_reg;
            c_col_reg   <= b_col_reg;
            c_glyph_reg <= b_space_reg ? tlms_pkg::SPACE_CHAR : rd_data_reg;
            c_last_reg  <= b_last_reg;
        end
    end

    assign m_valid       = c_valid_reg;
    assign m_row         = c_row_reg;
    assign m_column      = c_col_reg;
    assign m_glyph       = c_glyph_reg;
    assign m_last_of_run = c_last_reg;

endmodule
`default_nettype wire
